// File: hdl/bprm_pkg.sv
// Shared types and constants for the battery pack rule monitor.
package bprm_pkg;

	localparam int RULE_COUNT = 8;
	localparam int CELL_IDX_W = 7;
	localparam int CFG_ADDR_W = 6;
	localparam int CFG_DATA_W = 64;

	// Register indexes (byte address is 8 * index)
	localparam logic [2:0] REG_CELL_LIMITS = 3'd0;
	localparam logic [2:0] REG_TEMP_LIMITS = 3'd1;
	localparam logic [2:0] REG_PACK_OVER   = 3'd2;
	localparam logic [2:0] REG_PACK_UNDER  = 3'd3;
	localparam logic [2:0] REG_RELAY_MAP   = 3'd4;
	localparam logic [2:0] REG_RELAY_DEF   = 3'd5;

	localparam logic [63:0] RELAY_MAP_RESET = 64'hAAAA_AAAA_AAAA_AAAA;

	// Relay map codes
	localparam logic [1:0] MAP_CLR = 2'd0;
	localparam logic [1:0] MAP_SET = 2'd1;

	// Tracker constants
	localparam logic [7:0]  NO_PROBE_TEMP = 8'hD8;   // -40
	localparam logic [7:0]  TEMP_TOP_INIT = 8'h81;   // -127
	localparam logic [7:0]  TEMP_BOT_INIT = 8'h7F;   // 127
	localparam logic [15:0] CELL_BOT_INIT = 16'hFFFF;
	localparam logic [31:0] BANK_BOT_INIT = 32'hFFFF_FFFF;

	typedef struct packed {
		logic              cell_valid;
		logic [15:0]       cell_voltage_mv;
		logic signed [7:0] internal_temp;
		logic signed [7:0] external_temp;
		logic              last_of_bank;
		logic              last_of_scan;
	} in_item_t;

	typedef struct packed {
		logic [7:0]            rule_flags;
		logic [3:0]            relay_states;
		logic [3:0]            relay_changes;
		logic [15:0]           highest_cell_mv;
		logic [15:0]           lowest_cell_mv;
		logic [CELL_IDX_W-1:0] highest_cell_index;
		logic [CELL_IDX_W-1:0] lowest_cell_index;
		logic [31:0]           highest_pack_mv;
		logic [31:0]           lowest_pack_mv;
		logic                  zero_cell_seen;
	} out_item_t;

	typedef struct packed {
		logic [63:0] cell_voltage_limits;
		logic [63:0] temperature_limits;
		logic [63:0] pack_over_limits;
		logic [63:0] pack_under_limits;
		logic [63:0] relay_map;
		logic [3:0]  relay_defaults;
	} cfg_t;

endpackage

// File: hdl/bprm_cfg_regs.sv
// APB-style configuration register file for the battery pack rule monitor.
module bprm_cfg_regs
	import bprm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	cfg_t       cfg_q;
	logic [2:0] reg_idx;
	logic       wr_en;

	assign reg_idx = paddr[CFG_ADDR_W-1:3];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	// Register writes in the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cell_voltage_limits <= '0;
			cfg_q.temperature_limits  <= '0;
			cfg_q.pack_over_limits    <= '0;
			cfg_q.pack_under_limits   <= '0;
			cfg_q.relay_map           <= RELAY_MAP_RESET;
			cfg_q.relay_defaults      <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_CELL_LIMITS: cfg_q.cell_voltage_limits <= pwdata;
				REG_TEMP_LIMITS: cfg_q.temperature_limits  <= pwdata;
				REG_PACK_OVER:   cfg_q.pack_over_limits    <= pwdata;
				REG_PACK_UNDER:  cfg_q.pack_under_limits   <= pwdata;
				REG_RELAY_MAP:   cfg_q.relay_map           <= pwdata;
				REG_RELAY_DEF:   cfg_q.relay_defaults      <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		case (reg_idx)
			REG_CELL_LIMITS: prdata = cfg_q.cell_voltage_limits;
			REG_TEMP_LIMITS: prdata = cfg_q.temperature_limits;
			REG_PACK_OVER:   prdata = cfg_q.pack_over_limits;
			REG_PACK_UNDER:  prdata = cfg_q.pack_under_limits;
			REG_RELAY_MAP:   prdata = cfg_q.relay_map;
			REG_RELAY_DEF:   prdata = {60'b0, cfg_q.relay_defaults};
			default:         prdata = '0;
		endcase
	end

endmodule

// File: hdl/battery_pack_rule_monitor_top.sv
// Top level of the battery pack rule monitor: cell trackers, rules and relay mapping.
//
// Cell readings enter one item per clock while in_stall is low. Each item is
// held in an input register, where a single pass of logic (one saturating
// 32-bit add for the bank sum, its compares and the hysteresis and relay
// mapping) updates the trackers; an item that closes the scan writes its
// result into the output register, from which res_valid presents it. Items
// that do not close a scan keep flowing while a result waits; only a
// scan-closing item is held in the input register while the previous result
// is still stalled. Configuration registers sit at byte address 8 * index on
// the 64-bit APB-style port and reset at once; there is no clearing pass.
module battery_pack_rule_monitor_top
	import bprm_pkg::*;
#(
	parameter int RELAY_COUNT = 4,
	parameter int MAX_CELLS   = 128
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_item_t              in_data,
	output logic                  res_valid,
	input  logic                  res_stall,
	output out_item_t             res_data,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready
);

	localparam int CNT_W = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_CELLS - 1);
	localparam logic [3:0] RELAY_MASK = 4'((1 << RELAY_COUNT) - 1);

	cfg_t cfg;

	bprm_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Hysteresis: set on trip while clear, clear on release while set
	function automatic logic hyst(input logic cur, input logic trip, input logic release_c);
		logic r;
		r = cur;
		if (!cur && trip)
			r = 1'b1;
		else if (cur && release_c)
			r = 1'b0;
		return r;
	endfunction

	// Input register
	logic     valid_s1;
	in_item_t item_s1;
	logic     proc_go;

	// Tracker state
	logic [CNT_W-1:0]      cnt_q;
	logic [31:0]           bank_sum_q;
	logic [15:0]           top_mv_q, bot_mv_q;
	logic [CELL_IDX_W-1:0] top_idx_q, bot_idx_q;
	logic [31:0]           top_bank_q, bot_bank_q;
	logic [7:0]            top_ext_q, bot_ext_q, top_int_q, bot_int_q;
	logic                  probe_q, zero_q;
	logic [7:0]            rule_q;
	logic [3:0]            prev_relays_q;

	// Output register
	logic      res_valid_q;
	out_item_t res_data_q;

	assign proc_go   = valid_s1 && !(item_s1.last_of_scan && res_valid_q && res_stall);
	assign in_stall  = valid_s1 && !proc_go;
	assign res_valid = res_valid_q;
	assign res_data  = res_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1 <= in_data;
		end
	end

	// Next tracker values for the item in the input register
	logic                  v, close, scan_end, probe_hit;
	logic [15:0]           mv;
	logic [7:0]            itemp, etemp;
	logic [CELL_IDX_W-1:0] idx;
	logic [32:0]           sum_ext;
	logic [31:0]           sum_new;
	logic [15:0]           top_mv_n, bot_mv_n;
	logic [CELL_IDX_W-1:0] top_idx_n, bot_idx_n;
	logic [31:0]           top_bank_n, bot_bank_n;
	logic [7:0]            top_ext_n, bot_ext_n, top_int_n, bot_int_n;
	logic                  probe_n, zero_n;
	logic [CNT_W-1:0]      cnt_n;

	always_comb begin
		v         = item_s1.cell_valid;
		mv        = item_s1.cell_voltage_mv;
		itemp     = item_s1.internal_temp;
		etemp     = item_s1.external_temp;
		scan_end  = item_s1.last_of_scan;
		close     = item_s1.last_of_bank || scan_end;
		idx       = CELL_IDX_W'(cnt_q);
		probe_hit = v && (etemp != NO_PROBE_TEMP);

		// saturating bank sum
		sum_ext = {1'b0, bank_sum_q} + {17'b0, mv};
		if (!v)
			sum_new = bank_sum_q;
		else if (sum_ext[32])
			sum_new = BANK_BOT_INIT;
		else
			sum_new = sum_ext[31:0];

		zero_n  = zero_q || (v && (mv == 16'd0));
		probe_n = probe_q || probe_hit;

		top_mv_n  = top_mv_q;
		top_idx_n = top_idx_q;
		if (v && (mv > top_mv_q)) begin
			top_mv_n  = mv;
			top_idx_n = idx;
		end
		bot_mv_n  = bot_mv_q;
		bot_idx_n = bot_idx_q;
		if (v && (mv < bot_mv_q)) begin
			bot_mv_n  = mv;
			bot_idx_n = idx;
		end

		// temperature extremes, signed
		top_ext_n = (probe_hit && ($signed(etemp) > $signed(top_ext_q))) ? etemp : top_ext_q;
		bot_ext_n = (probe_hit && ($signed(etemp) < $signed(bot_ext_q))) ? etemp : bot_ext_q;
		top_int_n = (v && ($signed(itemp) > $signed(top_int_q))) ? itemp : top_int_q;
		bot_int_n = (v && ($signed(itemp) < $signed(bot_int_q))) ? itemp : bot_int_q;

		top_bank_n = (close && (sum_new > top_bank_q)) ? sum_new : top_bank_q;
		bot_bank_n = (close && (sum_new < bot_bank_q)) ? sum_new : bot_bank_q;

		cnt_n = (cnt_q == CNT_LAST) ? '0 : cnt_q + 1'b1;
	end

	// Rules on the closing values; bank compares split so they run beside the add
	logic [31:0] po_trip, po_rel, pu_trip, pu_rel;
	logic        bank_over_trip, bank_over_rel, bank_under_trip, bank_under_rel;
	logic [7:0]  rule_n;
	logic [3:0]  relays;

	always_comb begin
		po_trip = cfg.pack_over_limits[31:0];
		po_rel  = cfg.pack_over_limits[63:32];
		pu_trip = cfg.pack_under_limits[31:0];
		pu_rel  = cfg.pack_under_limits[63:32];

		bank_over_trip  = (top_bank_q > po_trip) || (close && (sum_new > po_trip));
		bank_over_rel   = (top_bank_q < po_rel) && (!close || (sum_new < po_rel));
		bank_under_trip = (bot_bank_q < pu_trip) || (close && (sum_new < pu_trip));
		bank_under_rel  = (bot_bank_q > pu_rel) && (!close || (sum_new > pu_rel));

		if (zero_n) begin
			// zero-volt cell: module rules cleared, bank rules held
			rule_n = {rule_q[7:6], 6'b0};
		end else begin
			rule_n[0] = hyst(rule_q[0], top_mv_n > cfg.cell_voltage_limits[15:0],
				top_mv_n < cfg.cell_voltage_limits[31:16]);
			rule_n[1] = hyst(rule_q[1], bot_mv_n < cfg.cell_voltage_limits[47:32],
				bot_mv_n > cfg.cell_voltage_limits[63:48]);
			if (probe_n) begin
				rule_n[2] = hyst(rule_q[2], top_ext_n > cfg.temperature_limits[7:0],
					top_ext_n < cfg.temperature_limits[15:8]);
				rule_n[3] = hyst(rule_q[3], bot_ext_n < cfg.temperature_limits[23:16],
					bot_ext_n > cfg.temperature_limits[31:24]);
			end else begin
				rule_n[3:2] = 2'b00;
			end
			rule_n[4] = hyst(rule_q[4], top_int_n > cfg.temperature_limits[39:32],
				top_int_n < cfg.temperature_limits[47:40]);
			rule_n[5] = hyst(rule_q[5], bot_int_n < cfg.temperature_limits[55:48],
				bot_int_n > cfg.temperature_limits[63:56]);
			rule_n[6] = hyst(rule_q[6], bank_over_trip, bank_over_rel);
			rule_n[7] = hyst(rule_q[7], bank_under_trip, bank_under_rel);
		end

		// relay mapping, highest rule first so the lowest active rule wins
		relays = cfg.relay_defaults & RELAY_MASK;
		for (int n = RULE_COUNT - 1; n >= 0; n--) begin
			for (int y = 0; y < RELAY_COUNT; y++) begin
				if (rule_n[n]) begin
					if (cfg.relay_map[(n * 4 + y) * 2 +: 2] == MAP_SET)
						relays[y] = 1'b1;
					else if (cfg.relay_map[(n * 4 + y) * 2 +: 2] == MAP_CLR)
						relays[y] = 1'b0;
				end
			end
		end
		relays = relays & RELAY_MASK;
	end

	// Tracker update, cleared at scan end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q         <= '0;
			bank_sum_q    <= '0;
			top_mv_q      <= '0;
			bot_mv_q      <= CELL_BOT_INIT;
			top_idx_q     <= '0;
			bot_idx_q     <= '0;
			top_bank_q    <= '0;
			bot_bank_q    <= BANK_BOT_INIT;
			top_ext_q     <= TEMP_TOP_INIT;
			bot_ext_q     <= TEMP_BOT_INIT;
			top_int_q     <= TEMP_TOP_INIT;
			bot_int_q     <= TEMP_BOT_INIT;
			probe_q       <= 1'b0;
			zero_q        <= 1'b0;
			rule_q        <= '0;
			prev_relays_q <= '0;
		end else if (proc_go) begin
			top_idx_q <= top_idx_n;
			bot_idx_q <= bot_idx_n;
			if (scan_end) begin
				cnt_q         <= '0;
				bank_sum_q    <= '0;
				top_mv_q      <= '0;
				bot_mv_q      <= CELL_BOT_INIT;
				top_bank_q    <= '0;
				bot_bank_q    <= BANK_BOT_INIT;
				top_ext_q     <= TEMP_TOP_INIT;
				bot_ext_q     <= TEMP_BOT_INIT;
				top_int_q     <= TEMP_TOP_INIT;
				bot_int_q     <= TEMP_BOT_INIT;
				probe_q       <= 1'b0;
				zero_q        <= 1'b0;
				rule_q        <= rule_n;
				prev_relays_q <= relays;
			end else begin
				cnt_q      <= cnt_n;
				bank_sum_q <= close ? 32'd0 : sum_new;
				top_mv_q   <= top_mv_n;
				bot_mv_q   <= bot_mv_n;
				top_bank_q <= top_bank_n;
				bot_bank_q <= bot_bank_n;
				top_ext_q  <= top_ext_n;
				bot_ext_q  <= bot_ext_n;
				top_int_q  <= top_int_n;
				bot_int_q  <= bot_int_n;
				probe_q    <= probe_n;
				zero_q     <= zero_n;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (proc_go && scan_end) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc_go && scan_end) begin
			res_data_q.rule_flags         <= rule_n;
			res_data_q.relay_states       <= relays;
			res_data_q.relay_changes      <= relays ^ prev_relays_q;
			res_data_q.highest_cell_mv    <= top_mv_n;
			res_data_q.lowest_cell_mv     <= bot_mv_n;
			res_data_q.highest_cell_index <= top_idx_n;
			res_data_q.lowest_cell_index  <= bot_idx_n;
			res_data_q.highest_pack_mv    <= top_bank_n;
			res_data_q.lowest_pack_mv     <= bot_bank_n;
			res_data_q.zero_cell_seen     <= zero_n;
		end
	end

endmodule
